### hw/rtl/csh_pkg.sv
// shared constants, codes and helpers for the circle sector hit test
package csh_pkg;

  localparam int CSH_COORD_BITS = 15;
  localparam int CSH_MARGIN     = 16;
  localparam int CSH_ADDR_BITS  = 5;
  localparam int CSH_DATA_BITS  = 32;

  // register reset values
  localparam int CSH_CENTER_X_RST = 0;
  localparam int CSH_CENTER_Y_RST = 0;
  localparam int CSH_EDGE1_X_RST  = 64;
  localparam int CSH_EDGE1_Y_RST  = 0;
  localparam int CSH_EDGE2_X_RST  = 0;
  localparam int CSH_EDGE2_Y_RST  = 64;

  typedef enum logic [2:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_EDGE1_X  = 3'd2,
    REG_EDGE1_Y  = 3'd3,
    REG_EDGE2_X  = 3'd4,
    REG_EDGE2_Y  = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    DEC_BEYOND = 3'd0,
    DEC_ANGLE  = 3'd1,
    DEC_EDGE1  = 3'd2,
    DEC_EDGE2  = 3'd3,
    DEC_MISS   = 3'd4
  } dec_t;

  // half-plane class of a direction relative to edge1, in ccw order
  typedef enum logic [1:0] {
    HC_ZERO  = 2'd0,
    HC_UPPER = 2'd1,
    HC_PI    = 2'd2,
    HC_LOWER = 2'd3
  } hc_t;

  function automatic hc_t half_class(input logic cr_neg, input logic cr_zero,
                                     input logic dt_neg);
    hc_t hc;
    if (!cr_zero && !cr_neg) begin
      hc = HC_UPPER;
    end else if (cr_neg) begin
      hc = HC_LOWER;
    end else if (dt_neg) begin
      hc = HC_PI;
    end else begin
      hc = HC_ZERO;
    end
    return hc;
  endfunction

endpackage

### hw/rtl/circle_sector_hit_test.sv
// circle sector hit test top level: register port and six-stage datapath
// Takes one point request per clock while no finished result is held by
// out_stall; returns one result (hit, deciding test) per request, in order,
// on out_valid after six register stages, all advancing together.
// in_stall rises only while a finished result is held by out_stall.
// Registers must be written over the APB port only while no request is in
// flight; the block does not enforce this. Derived constants are registered
// in product, sum and late levels, which the pipeline depth covers, so a
// request may follow a write in the next cycle.
module circle_sector_hit_test import csh_pkg::*; #(
  parameter int COORD_BITS = CSH_COORD_BITS,
  parameter int MARGIN     = CSH_MARGIN
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_pos_x,
  input  logic signed [COORD_BITS-1:0] in_pos_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic [2:0]                   out_decided_by,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CSH_ADDR_BITS-1:0]     paddr,
  input  logic [CSH_DATA_BITS-1:0]     pwdata,
  output logic [CSH_DATA_BITS-1:0]     prdata,
  output logic                         pready
);

  logic signed [COORD_BITS-1:0]   cx, cy, ax, ay, bx, by;
  logic signed [2*COORD_BITS+2:0] rsq, e2b, rsqm;
  hc_t                            kw;
  logic [4*COORD_BITS+1:0]        k4r, m2e2a, m2e2b;

  csh_cfg #(
    .COORD_BITS(COORD_BITS),
    .MARGIN    (MARGIN)
  ) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cx     (cx),
    .cy     (cy),
    .ax     (ax),
    .ay     (ay),
    .bx     (bx),
    .by     (by),
    .rsq    (rsq),
    .e2b    (e2b),
    .rsqm   (rsqm),
    .kw     (kw),
    .k4r    (k4r),
    .m2e2a  (m2e2a),
    .m2e2b  (m2e2b)
  );

  csh_pipe #(
    .COORD_BITS(COORD_BITS),
    .MARGIN    (MARGIN)
  ) u_pipe (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .cx            (cx),
    .cy            (cy),
    .ax            (ax),
    .ay            (ay),
    .bx            (bx),
    .by            (by),
    .rsq           (rsq),
    .e2b           (e2b),
    .rsqm          (rsqm),
    .kw            (kw),
    .k4r           (k4r),
    .m2e2a         (m2e2a),
    .m2e2b         (m2e2b),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit),
    .out_decided_by(out_decided_by)
  );

endmodule

### hw/rtl/csh_cfg.sv
// configuration registers and the sector constants derived from them
module csh_cfg import csh_pkg::*; #(
  parameter int COORD_BITS = CSH_COORD_BITS,
  parameter int MARGIN     = CSH_MARGIN
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [CSH_ADDR_BITS-1:0]       paddr,
  input  logic [CSH_DATA_BITS-1:0]       pwdata,
  output logic [CSH_DATA_BITS-1:0]       prdata,
  output logic                           pready,
  output logic signed [COORD_BITS-1:0]   cx,
  output logic signed [COORD_BITS-1:0]   cy,
  output logic signed [COORD_BITS-1:0]   ax,
  output logic signed [COORD_BITS-1:0]   ay,
  output logic signed [COORD_BITS-1:0]   bx,
  output logic signed [COORD_BITS-1:0]   by,
  output logic signed [2*COORD_BITS+2:0] rsq,
  output logic signed [2*COORD_BITS+2:0] e2b,
  output logic signed [2*COORD_BITS+2:0] rsqm,
  output hc_t                            kw,
  output logic [4*COORD_BITS+1:0]        k4r,
  output logic [4*COORD_BITS+1:0]        m2e2a,
  output logic [4*COORD_BITS+1:0]        m2e2b
);

  localparam int CW = COORD_BITS;
  localparam int PW = 2 * (CW + 1);
  localparam int SW = PW + 1;
  localparam int MW = 2 * CW + 1;
  localparam int QW = 2 * MW;
  localparam int M2 = MARGIN * MARGIN;
  localparam int K4 = 4 * M2;

  logic signed [CW-1:0] cx_r, cy_r, ax_r, ay_r, bx_r, by_r;
  logic                 wr_en;
  reg_idx_t             idx;

  // first level: products of edge components
  logic signed [PW-1:0] axax_r, ayay_r, bxbx_r, byby_r;
  logic signed [PW-1:0] axby_r, aybx_r, axbx_r, ayby_r;
  // second level: sums
  logic signed [SW-1:0] rsq_r, e2b_r, crab_r, dtab_r;
  // third level: constants used late in the pipe
  hc_t                  kw_r;
  logic signed [SW-1:0] rsqm_r;
  logic [QW-1:0]        k4r_r, m2e2a_r, m2e2b_r;

  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[CSH_ADDR_BITS-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= CW'(CSH_CENTER_X_RST);
      cy_r <= CW'(CSH_CENTER_Y_RST);
      ax_r <= CW'(CSH_EDGE1_X_RST);
      ay_r <= CW'(CSH_EDGE1_Y_RST);
      bx_r <= CW'(CSH_EDGE2_X_RST);
      by_r <= CW'(CSH_EDGE2_Y_RST);
    end else if (wr_en) begin
      unique case (idx)
        REG_CENTER_X: cx_r <= $signed(pwdata[CW-1:0]);
        REG_CENTER_Y: cy_r <= $signed(pwdata[CW-1:0]);
        REG_EDGE1_X:  ax_r <= $signed(pwdata[CW-1:0]);
        REG_EDGE1_Y:  ay_r <= $signed(pwdata[CW-1:0]);
        REG_EDGE2_X:  bx_r <= $signed(pwdata[CW-1:0]);
        REG_EDGE2_Y:  by_r <= $signed(pwdata[CW-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CENTER_X: prdata = CSH_DATA_BITS'(cx_r);
      REG_CENTER_Y: prdata = CSH_DATA_BITS'(cy_r);
      REG_EDGE1_X:  prdata = CSH_DATA_BITS'(ax_r);
      REG_EDGE1_Y:  prdata = CSH_DATA_BITS'(ay_r);
      REG_EDGE2_X:  prdata = CSH_DATA_BITS'(bx_r);
      REG_EDGE2_Y:  prdata = CSH_DATA_BITS'(by_r);
      default:      prdata = '0;
    endcase
  end

  // recomputed every cycle: products, then sums, then the late constants
  always_ff @(posedge clk) begin
    axax_r  <= PW'(ax_r) * PW'(ax_r);
    ayay_r  <= PW'(ay_r) * PW'(ay_r);
    bxbx_r  <= PW'(bx_r) * PW'(bx_r);
    byby_r  <= PW'(by_r) * PW'(by_r);
    axby_r  <= PW'(ax_r) * PW'(by_r);
    aybx_r  <= PW'(ay_r) * PW'(bx_r);
    axbx_r  <= PW'(ax_r) * PW'(bx_r);
    ayby_r  <= PW'(ay_r) * PW'(by_r);

    rsq_r   <= SW'(axax_r) + SW'(ayay_r);
    e2b_r   <= SW'(bxbx_r) + SW'(byby_r);
    crab_r  <= SW'(axby_r) - SW'(aybx_r);
    dtab_r  <= SW'(axbx_r) + SW'(ayby_r);

    kw_r    <= half_class(crab_r[SW-1], crab_r == '0, dtab_r[SW-1]);
    rsqm_r  <= rsq_r + SW'(M2);
    k4r_r   <= QW'(QW'(rsq_r) * QW'(K4));
    m2e2a_r <= QW'(QW'(rsq_r) * QW'(M2));
    m2e2b_r <= QW'(QW'(e2b_r) * QW'(M2));
  end

  assign cx    = cx_r;
  assign cy    = cy_r;
  assign ax    = ax_r;
  assign ay    = ay_r;
  assign bx    = bx_r;
  assign by    = by_r;
  assign rsq   = rsq_r;
  assign e2b   = e2b_r;
  assign rsqm  = rsqm_r;
  assign kw    = kw_r;
  assign k4r   = k4r_r;
  assign m2e2a = m2e2a_r;
  assign m2e2b = m2e2b_r;

endmodule

### hw/rtl/csh_pipe.sv
// six-stage datapath: offset, products, sums, compares, squares, decision
module csh_pipe import csh_pkg::*; #(
  parameter int COORD_BITS = CSH_COORD_BITS,
  parameter int MARGIN     = CSH_MARGIN
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [COORD_BITS-1:0]   in_pos_x,
  input  logic signed [COORD_BITS-1:0]   in_pos_y,
  input  logic signed [COORD_BITS-1:0]   cx,
  input  logic signed [COORD_BITS-1:0]   cy,
  input  logic signed [COORD_BITS-1:0]   ax,
  input  logic signed [COORD_BITS-1:0]   ay,
  input  logic signed [COORD_BITS-1:0]   bx,
  input  logic signed [COORD_BITS-1:0]   by,
  input  logic signed [2*COORD_BITS+2:0] rsq,
  input  logic signed [2*COORD_BITS+2:0] e2b,
  input  logic signed [2*COORD_BITS+2:0] rsqm,
  input  hc_t                            kw,
  input  logic [4*COORD_BITS+1:0]        k4r,
  input  logic [4*COORD_BITS+1:0]        m2e2a,
  input  logic [4*COORD_BITS+1:0]        m2e2b,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_hit,
  output logic [2:0]                     out_decided_by
);

  localparam int CW  = COORD_BITS;
  localparam int VW  = CW + 1;
  localparam int PW  = 2 * VW;
  localparam int SW  = PW + 1;
  localparam int LSW = SW + 1;
  localparam int DW  = VW + 1;
  localparam int DQW = 2 * DW;
  localparam int DSW = DQW + 1;
  localparam int MW  = 2 * CW + 1;
  localparam int QW  = 2 * MW;
  localparam int M2  = MARGIN * MARGIN;

  typedef struct packed {
    logic lpos;        // beyond-radius candidate
    hc_t  kv;          // angle class of the point
    logic crv_pos;     // point is clockwise of edge2
    logic a_le0;       // projection on edge1 at or behind apex
    logic a_ge;        // projection at or past edge1 end
    logic b_le0;
    logic b_ge;
    logic apex_near;
    logic a_end_near;
    logic b_end_near;
  } flag_t;

  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;

  // stage 1
  logic signed [VW-1:0]  vx_r, vy_r, vx_nxt, vy_nxt;
  // stage 2
  logic signed [PW-1:0]  pxx_r, pyy_r, axvy_r, ayvx_r, axvx_r, ayvy_r;
  logic signed [PW-1:0]  byvx_r, bxvy_r, bxvx_r, byvy_r;
  logic signed [DW-1:0]  dxa_r, dya_r, dxb_r, dyb_r;
  logic signed [DW-1:0]  dxa_nxt, dya_nxt, dxb_nxt, dyb_nxt;
  // stage 3
  logic signed [SW-1:0]  dsq_r, cra_r, dta_r, crv_r, dtb_r;
  logic signed [DQW-1:0] dxa2_r, dya2_r, dxb2_r, dyb2_r;
  // stage 4
  logic signed [LSW-1:0] l_val;
  logic signed [SW-1:0]  cra_abs, crv_abs;
  logic signed [DSW-1:0] da_sum, db_sum;
  flag_t                 f4_nxt, f4_r;
  logic [MW-1:0]         lmag_r, ca_r, cb_r;
  // stage 5
  flag_t                 f5_r;
  logic [QW-1:0]         lsq_r, ca2_r, cb2_r;
  // output
  logic                  beyond, in_angle, near_a, near_b;
  dec_t                  dec_nxt;
  logic                  hit_r;
  dec_t                  dec_r;

  // the whole pipe holds only while a finished result waits downstream
  assign en       = !v6_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // stage 1: offset from apex
  assign vx_nxt = VW'(in_pos_x) - VW'(cx);
  assign vy_nxt = VW'(in_pos_y) - VW'(cy);

  // stage 2 inputs: offsets to edge ends
  assign dxa_nxt = DW'(vx_r) - DW'(ax);
  assign dya_nxt = DW'(vy_r) - DW'(ay);
  assign dxb_nxt = DW'(vx_r) - DW'(bx);
  assign dyb_nxt = DW'(vy_r) - DW'(by);

  // stage 4 inputs
  assign l_val   = LSW'(dsq_r) - LSW'(rsqm);
  assign cra_abs = cra_r[SW-1] ? -cra_r : cra_r;
  assign crv_abs = crv_r[SW-1] ? -crv_r : crv_r;
  assign da_sum  = DSW'(dxa2_r) + DSW'(dya2_r);
  assign db_sum  = DSW'(dxb2_r) + DSW'(dyb2_r);

  always_comb begin
    f4_nxt.lpos       = !l_val[LSW-1] && (l_val != '0);
    f4_nxt.kv         = half_class(cra_r[SW-1], cra_r == '0, dta_r[SW-1]);
    f4_nxt.crv_pos    = !crv_r[SW-1] && (crv_r != '0);
    f4_nxt.a_le0      = dta_r[SW-1] || (dta_r == '0);
    f4_nxt.a_ge       = dta_r >= rsq;
    f4_nxt.b_le0      = dtb_r[SW-1] || (dtb_r == '0);
    f4_nxt.b_ge       = dtb_r >= e2b;
    f4_nxt.apex_near  = dsq_r <= SW'(M2);
    f4_nxt.a_end_near = da_sum <= DSW'(M2);
    f4_nxt.b_end_near = db_sum <= DSW'(M2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx_r   <= vx_nxt;
      vy_r   <= vy_nxt;

      pxx_r  <= PW'(vx_r) * PW'(vx_r);
      pyy_r  <= PW'(vy_r) * PW'(vy_r);
      axvy_r <= PW'(ax) * PW'(vy_r);
      ayvx_r <= PW'(ay) * PW'(vx_r);
      axvx_r <= PW'(ax) * PW'(vx_r);
      ayvy_r <= PW'(ay) * PW'(vy_r);
      byvx_r <= PW'(by) * PW'(vx_r);
      bxvy_r <= PW'(bx) * PW'(vy_r);
      bxvx_r <= PW'(bx) * PW'(vx_r);
      byvy_r <= PW'(by) * PW'(vy_r);
      dxa_r  <= dxa_nxt;
      dya_r  <= dya_nxt;
      dxb_r  <= dxb_nxt;
      dyb_r  <= dyb_nxt;

      dsq_r  <= SW'(pxx_r) + SW'(pyy_r);
      cra_r  <= SW'(axvy_r) - SW'(ayvx_r);
      dta_r  <= SW'(axvx_r) + SW'(ayvy_r);
      // v x edge2; the edge2 cross for the distance test is its negation
      crv_r  <= SW'(byvx_r) - SW'(bxvy_r);
      dtb_r  <= SW'(bxvx_r) + SW'(byvy_r);
      dxa2_r <= DQW'(dxa_r) * DQW'(dxa_r);
      dya2_r <= DQW'(dya_r) * DQW'(dya_r);
      dxb2_r <= DQW'(dxb_r) * DQW'(dxb_r);
      dyb2_r <= DQW'(dyb_r) * DQW'(dyb_r);

      f4_r   <= f4_nxt;
      lmag_r <= l_val[MW-1:0];
      ca_r   <= cra_abs[MW-1:0];
      cb_r   <= crv_abs[MW-1:0];

      f5_r   <= f4_r;
      lsq_r  <= QW'(lmag_r) * QW'(lmag_r);
      ca2_r  <= QW'(ca_r) * QW'(ca_r);
      cb2_r  <= QW'(cb_r) * QW'(cb_r);

      hit_r  <= (dec_nxt != DEC_BEYOND) && (dec_nxt != DEC_MISS);
      dec_r  <= dec_nxt;
    end
  end

  // stage 6: decision
  always_comb begin
    beyond = f5_r.lpos && (lsq_r > k4r);
    if (f5_r.kv != kw) begin
      in_angle = f5_r.kv < kw;
    end else begin
      in_angle = (f5_r.kv == HC_UPPER || f5_r.kv == HC_LOWER) && f5_r.crv_pos;
    end
    if (f5_r.a_le0) begin
      near_a = f5_r.apex_near;
    end else if (f5_r.a_ge) begin
      near_a = f5_r.a_end_near;
    end else begin
      near_a = ca2_r <= m2e2a;
    end
    if (f5_r.b_le0) begin
      near_b = f5_r.apex_near;
    end else if (f5_r.b_ge) begin
      near_b = f5_r.b_end_near;
    end else begin
      near_b = cb2_r <= m2e2b;
    end
    if (beyond) begin
      dec_nxt = DEC_BEYOND;
    end else if (in_angle) begin
      dec_nxt = DEC_ANGLE;
    end else if (near_a) begin
      dec_nxt = DEC_EDGE1;
    end else if (near_b) begin
      dec_nxt = DEC_EDGE2;
    end else begin
      dec_nxt = DEC_MISS;
    end
  end

  assign out_valid      = v6_r;
  assign out_hit        = hit_r;
  assign out_decided_by = dec_r;

endmodule

### hw/rtl/csh_check.sv
// port-level checker for the circle sector hit test, bound to the top level
module csh_check import csh_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_hit,
  input logic [2:0] out_decided_by
);

  // results are gone right after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // stall on the input side only comes from a held result
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // hit agrees with the deciding test
  a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit == (out_decided_by == DEC_ANGLE ||
                               out_decided_by == DEC_EDGE1 ||
                               out_decided_by == DEC_EDGE2)))
    else $error("hit does not match decided_by");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_decided_by <= DEC_MISS))
    else $error("decided_by out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_hit) && $stable(out_decided_by)))
    else $error("stalled result changed");

endmodule

bind circle_sector_hit_test csh_check u_csh_check (.*);

### tb/csh_hit_checker.sv
// scoreboard for the circle sector hit test: tracks registers, predicts and checks results
module csh_hit_checker import csh_pkg::*; (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic signed [CSH_COORD_BITS-1:0] in_pos_x,
  input  logic signed [CSH_COORD_BITS-1:0] in_pos_y,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic                             out_hit,
  input  logic [2:0]                       out_decided_by,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [CSH_ADDR_BITS-1:0]         paddr,
  input  logic [CSH_DATA_BITS-1:0]         pwdata,
  output int                               pending,
  output int                               mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REG_COUNT = 6;
  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic hit;
    dec_t dec;
  } verdict_t;

  verdict_t                          verdict_q[$];
  logic signed [CSH_COORD_BITS-1:0]  sector_reg [REG_COUNT];
  int                                n_results;

  function automatic hc_t zone_of(longint cr, longint dt);
    if (cr > 0) begin
      return HC_UPPER;
    end else if (cr < 0) begin
      return HC_LOWER;
    end else if (dt >= 0) begin
      return HC_ZERO;
    end
    return HC_PI;
  endfunction

  // distance from v to the segment [0, e] is at most the margin
  function automatic logic near_edge(longint vx, longint vy, longint ex, longint ey);
    longint       m2, dt, e2, dx, dy, cr;
    logic [127:0] cr_w, m2_w, e2_w;
    m2 = CSH_MARGIN * CSH_MARGIN;
    dt = vx * ex + vy * ey;
    e2 = ex * ex + ey * ey;
    if (dt <= 0) return (vx * vx + vy * vy) <= m2;
    if (dt >= e2) begin
      dx = vx - ex;
      dy = vy - ey;
      return (dx * dx + dy * dy) <= m2;
    end
    cr = ex * vy - ey * vx;
    if (cr < 0) cr = -cr;
    cr_w = cr;
    m2_w = m2;
    e2_w = e2;
    return (cr_w * cr_w) <= (m2_w * e2_w);
  endfunction

  function automatic verdict_t predict_hit(logic signed [CSH_COORD_BITS-1:0] px,
                                           logic signed [CSH_COORD_BITS-1:0] py);
    longint       cx, cy, ax, ay, bx, by, vx, vy, dsq, rsq, slack;
    logic [127:0] slack_w, rsq_w, k_w;
    hc_t          kv, kw;
    logic         in_angle;
    verdict_t     r;
    cx = sector_reg[REG_CENTER_X];
    cy = sector_reg[REG_CENTER_Y];
    ax = sector_reg[REG_EDGE1_X];
    ay = sector_reg[REG_EDGE1_Y];
    bx = sector_reg[REG_EDGE2_X];
    by = sector_reg[REG_EDGE2_Y];
    vx = longint'(px) - cx;
    vy = longint'(py) - cy;
    dsq = vx * vx + vy * vy;
    rsq = ax * ax + ay * ay;
    slack = dsq - rsq - CSH_MARGIN * CSH_MARGIN;
    slack_w = slack;
    rsq_w = rsq;
    k_w = 4 * CSH_MARGIN * CSH_MARGIN;
    r.hit = 1'b0;
    r.dec = DEC_MISS;
    // |v| > r + margin, squared twice so no root is needed
    if (slack > 0 && (slack_w * slack_w) > (k_w * rsq_w)) begin
      r.dec = DEC_BEYOND;
    end else begin
      kv = zone_of(ax * vy - ay * vx, ax * vx + ay * vy);
      kw = zone_of(ax * by - ay * bx, ax * bx + ay * by);
      if (kv != kw) begin
        in_angle = kv < kw;
      end else if (kv == HC_UPPER || kv == HC_LOWER) begin
        in_angle = (vx * by - vy * bx) > 0;
      end else begin
        in_angle = 1'b0;
      end
      if (in_angle) begin
        r.hit = 1'b1;
        r.dec = DEC_ANGLE;
      end else if (near_edge(vx, vy, ax, ay)) begin
        r.hit = 1'b1;
        r.dec = DEC_EDGE1;
      end else if (near_edge(vx, vy, bx, by)) begin
        r.hit = 1'b1;
        r.dec = DEC_EDGE2;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP) begin
      $display("[%0t] result %0d: %s: got %0d, expected %0d", $realtime, n_results, what,
               got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : score
    verdict_t want;
    if (!rst_n) begin
      sector_reg[REG_CENTER_X] <= CSH_COORD_BITS'(CSH_CENTER_X_RST);
      sector_reg[REG_CENTER_Y] <= CSH_COORD_BITS'(CSH_CENTER_Y_RST);
      sector_reg[REG_EDGE1_X]  <= CSH_COORD_BITS'(CSH_EDGE1_X_RST);
      sector_reg[REG_EDGE1_Y]  <= CSH_COORD_BITS'(CSH_EDGE1_Y_RST);
      sector_reg[REG_EDGE2_X]  <= CSH_COORD_BITS'(CSH_EDGE2_X_RST);
      sector_reg[REG_EDGE2_Y]  <= CSH_COORD_BITS'(CSH_EDGE2_Y_RST);
      verdict_q.delete();
      n_results = 0;
      mismatches = 0;
      pending <= 0;
    end else begin
      // prediction uses the registers as they stand before this edge
      if (in_valid && !in_stall) verdict_q.push_back(predict_hit(in_pos_x, in_pos_y));
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result with no request outstanding", out_decided_by, -1);
        end else begin
          want = verdict_q.pop_front();
          if (out_hit !== want.hit) report_mismatch("hit", out_hit, want.hit);
          if (out_decided_by !== want.dec) begin
            report_mismatch("decided_by", out_decided_by, want.dec);
          end
        end
        n_results++;
      end
      if (psel && penable && pwrite && pready && paddr[CSH_ADDR_BITS-1:2] < REG_COUNT) begin
        sector_reg[paddr[CSH_ADDR_BITS-1:2]] <= pwdata[CSH_COORD_BITS-1:0];
      end
      pending <= verdict_q.size();
    end
  end

endmodule

### tb/tb_circle_sector_hit_test.sv
// testbench top for the circle sector hit test: clock, reset, stimulus and verdict
module tb_circle_sector_hit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import csh_pkg::*;

  localparam int          SETTLE_CYCLES    = 12;
  localparam int          LONG_HOLD_CYCLES = 150;
  localparam int          RAND_PHASES      = 10;
  localparam int          PHASE_ITEMS      = 148;
  localparam int unsigned CYCLE_LIMIT      = 400000;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic signed [CSH_COORD_BITS-1:0] in_pos_x = '0;
  logic signed [CSH_COORD_BITS-1:0] in_pos_y = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             out_hit;
  logic [2:0]                       out_decided_by;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [CSH_ADDR_BITS-1:0]         paddr = '0;
  logic [CSH_DATA_BITS-1:0]         pwdata = '0;
  logic [CSH_DATA_BITS-1:0]         prdata;
  logic                             pready;

  int          pending;
  int          mismatches;
  int unsigned cycles = 0;
  logic        burst_mode = 1'b0;
  logic        long_hold = 1'b0;
  longint      sector_now [6];

  circle_sector_hit_test u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_decided_by (out_decided_by),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  csh_hit_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_decided_by (out_decided_by),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pending        (pending),
    .mismatches     (mismatches)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int draw_wait();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
  endfunction

  function automatic logic signed [CSH_COORD_BITS-1:0] fold_coord(longint v);
    return v[CSH_COORD_BITS-1:0];
  endfunction

  function automatic longint abs_l(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint rand_span(longint lim);
    return longint'($urandom_range(0, 32'(2 * lim))) - lim;
  endfunction

  // result side: random stall per result, one long hold on request
  initial begin : receiver
    int hold;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
      hold = burst_mode ? 0 : draw_wait();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_point(input logic signed [CSH_COORD_BITS-1:0] x,
                            input logic signed [CSH_COORD_BITS-1:0] y, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= x;
    in_pos_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drop valid and wait until every request has its result
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input longint val);
    logic signed [CSH_COORD_BITS-1:0] w;
    w = fold_coord(val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= CSH_DATA_BITS'(w);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sector_now[idx] = w;
  endtask

  task automatic set_sector(input longint cx, input longint cy, input longint ax,
                            input longint ay, input longint bx, input longint by);
    settle();
    reg_write(REG_CENTER_X, cx);
    reg_write(REG_CENTER_Y, cy);
    reg_write(REG_EDGE1_X, ax);
    reg_write(REG_EDGE1_Y, ay);
    reg_write(REG_EDGE2_X, bx);
    reg_write(REG_EDGE2_Y, by);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_sector();
    longint      ax, ay, bx, by, k;
    int unsigned r;
    r = $urandom_range(0, 99);
    ax = rand_span(200);
    ay = rand_span(200);
    bx = rand_span(200);
    by = rand_span(200);
    if (r < 35) begin
      // small sector, defaults above
    end else if (r < 50) begin
      // edge2 on the line of edge1
      k = rand_span(3);
      bx = ax * k;
      by = ay * k;
    end else if (r < 65) begin
      ax = rand_span(16384);
      ay = rand_span(16384);
      bx = rand_span(16384);
      by = rand_span(16384);
    end else if (r < 80) begin
      if ($urandom_range(0, 1) == 0) begin
        ax = 0;
        ay = 0;
      end else begin
        bx = 0;
        by = 0;
      end
    end else begin
      ax = rand_span(2000);
      ay = rand_span(2000);
      bx = rand_span(2000);
      by = rand_span(2000);
    end
    set_sector(rand_span(16384), rand_span(16384), ax, ay, bx, by);
  endtask

  task automatic random_point(output logic signed [CSH_COORD_BITS-1:0] px,
                              output logic signed [CSH_COORD_BITS-1:0] py);
    longint      reach, ox, oy, ex, ey, t;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    reach = abs_l(sector_now[REG_EDGE1_X]) + abs_l(sector_now[REG_EDGE1_Y]) +
            2 * CSH_MARGIN + 8;
    if (pick < 6) begin
      ox = rand_span(reach);
      oy = rand_span(reach);
    end else if (pick < 8) begin
      // skim along one edge segment
      ex = (pick == 6) ? sector_now[REG_EDGE1_X] : sector_now[REG_EDGE2_X];
      ey = (pick == 6) ? sector_now[REG_EDGE1_Y] : sector_now[REG_EDGE2_Y];
      t = $urandom_range(0, 40);
      ox = ex * t / 32 + rand_span(24);
      oy = ey * t / 32 + rand_span(24);
    end else begin
      ox = rand_span(32768);
      oy = rand_span(32768);
    end
    px = fold_coord(sector_now[REG_CENTER_X] + ox);
    py = fold_coord(sector_now[REG_CENTER_Y] + oy);
  endtask

  initial begin : stimulus
    logic signed [CSH_COORD_BITS-1:0] px, py;
    sector_now[REG_CENTER_X] = CSH_CENTER_X_RST;
    sector_now[REG_CENTER_Y] = CSH_CENTER_Y_RST;
    sector_now[REG_EDGE1_X]  = CSH_EDGE1_X_RST;
    sector_now[REG_EDGE1_Y]  = CSH_EDGE1_Y_RST;
    sector_now[REG_EDGE2_X]  = CSH_EDGE2_X_RST;
    sector_now[REG_EDGE2_Y]  = CSH_EDGE2_Y_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset sector: quarter disk of radius 64
    send_point(0, 0, draw_wait());
    send_point(16383, 16383, draw_wait());
    send_point(-16384, -16384, draw_wait());
    send_point(16383, -16384, draw_wait());
    send_point(-16384, 16383, draw_wait());
    send_point(80, 0, draw_wait());
    send_point(81, 0, draw_wait());
    send_point(0, 80, draw_wait());
    send_point(-16, 0, draw_wait());
    send_point(-17, 0, draw_wait());
    send_point(30, -16, draw_wait());
    send_point(30, -17, draw_wait());
    send_point(40, 40, draw_wait());
    // edge2 along edge1
    set_sector(0, 0, 128, 0, 256, 0);
    send_point(0, 0, draw_wait());
    send_point(50, 5, draw_wait());
    // zero first edge
    set_sector(100, -100, 0, 0, 30, 40);
    send_point(116, -100, draw_wait());
    send_point(100, -83, draw_wait());
    // zero edge2
    set_sector(0, 0, 100, 0, 0, 0);
    send_point(-10, -10, draw_wait());
    send_point(50, -30, draw_wait());
    // extreme registers
    set_sector(-16384, -16384, 16383, 16383, -16384, 16383);
    send_point(16383, 16383, draw_wait());
    send_point(-16384, -16384, draw_wait());
    set_sector(16383, 16383, -16384, -16384, 16383, -16384);
    send_point(-16384, -16384, draw_wait());
    send_point(0, 0, draw_wait());

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      random_sector();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 30 == 0) burst_mode = ($urandom_range(0, 3) == 0);
        // receiver holds off while requests keep coming
        if (ph == 2 && n == 20) long_hold = 1'b1;
        if (ph == 5 && n == 75) settle();
        random_point(px, py);
        send_point(px, py, burst_mode ? 0 : draw_wait());
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
